### hw/rtl/b64_pkg.sv
// Shared types and constants for the base64 codec.
package b64_pkg;

    localparam int B64_QUEUE_DEPTH = 2;

    localparam logic B64_MODE_ENCODE = 1'b0;
    localparam logic B64_MODE_DECODE = 1'b1;

    // One group handed from the front to the back.
    typedef struct packed {
        logic        dec;    // 1: three data bytes, 0: four characters
        logic [1:0]  cnt;    // encode: bytes held in the group, 1 to 3
        logic [23:0] bits;   // group, left aligned, zero filled
    } t_job;

endpackage

### hw/rtl/b64_ifs.sv
// Stream interfaces for the codec input and result channels.
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

### hw/rtl/b64_front.sv
// Front end: takes input beats, gathers groups and issues jobs to the queue.
module b64_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic                 i_q_full,
    output logic                 o_push,
    output b64_pkg::t_job        o_job
);
    import b64_pkg::*;

    logic        r_mode;
    logic [23:0] r_bits;
    logic [1:0]  r_count;
    logic [23:0] n_bits;
    logic [1:0]  n_count;

    logic [2:0]  cnt;
    logic [23:0] enc_bits;
    logic [23:0] dec_bits;
    logic [5:0]  sextet;
    logic        emit;
    logic        accept;

    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] v;
        v = 6'd0;
        if (c == 8'h2b) begin
            v = 6'd62;
        end else if (c == 8'h2f) begin
            v = 6'd63;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 6'(c - 8'h30 + 8'd52);
        end else if (c >= 8'h41 && c <= 8'h5a) begin
            v = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            v = 6'(c - 8'h61 + 8'd26);
        end
        return v;
    endfunction

    always_comb begin
        cnt      = {1'b0, r_count} + 3'd1;
        sextet   = sextet_of(i_byte);
        enc_bits = {r_bits[15:0], i_byte};
        dec_bits = {r_bits[17:0], sextet};
        o_job.dec = r_mode;
        o_job.cnt = cnt[1:0];
        if (r_mode == B64_MODE_ENCODE) begin
            emit = (cnt == 3'd3) || i_last;
            case (cnt)
                3'd1:    o_job.bits = {enc_bits[7:0], 16'h0000};
                3'd2:    o_job.bits = {enc_bits[15:0], 8'h00};
                default: o_job.bits = enc_bits;
            endcase
        end else begin
            emit       = (cnt == 3'd4);
            o_job.bits = dec_bits;
        end
    end

    // No job slot check per beat: hold off intake whenever the queue is full.
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && emit;

    always_comb begin
        n_bits  = r_bits;
        n_count = r_count;
        if (accept) begin
            if (emit || i_last) begin
                n_bits  = 24'h000000;
                n_count = 2'd0;
            end else begin
                n_bits  = (r_mode == B64_MODE_ENCODE) ? enc_bits : dec_bits;
                n_count = cnt[1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= B64_MODE_ENCODE;
            r_bits  <= 24'h000000;
            r_count <= 2'd0;
        end else if (i_cfg_we) begin
            r_mode  <= i_cfg_wdata;
            r_bits  <= 24'h000000;
            r_count <= 2'd0;
        end else begin
            r_bits  <= n_bits;
            r_count <= n_count;
        end
    end

endmodule

### hw/rtl/b64_fifo.sv
// Short job queue between the front and the back.
module b64_fifo #(
    parameter int DEPTH = b64_pkg::B64_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  b64_pkg::t_job        i_job,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output b64_pkg::t_job        o_job
);
    import b64_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

### hw/rtl/b64_back.sv
// Back end: serializes each job into result beats through an output register.
module b64_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  b64_pkg::t_job        i_q_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_byte,
    output logic                 o_last
);
    import b64_pkg::*;

    t_job       r_job;
    logic       r_busy;
    logic [1:0] r_k;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    logic       out_free;
    logic       emit;
    logic       job_end;
    logic [5:0] idx;
    logic       pad;
    logic [7:0] beat_byte;

    function automatic logic [7:0] char_of(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 8'h2b;
        end else begin
            c = 8'h2f;
        end
        return c;
    endfunction

    always_comb begin
        case (r_k)
            2'd0:    idx = r_job.bits[23:18];
            2'd1:    idx = r_job.bits[17:12];
            2'd2:    idx = r_job.bits[11:6];
            default: idx = r_job.bits[5:0];
        endcase
        pad = ((r_k == 2'd2) && (r_job.cnt < 2'd2)) ||
              ((r_k == 2'd3) && (r_job.cnt < 2'd3));
        if (r_job.dec) begin
            case (r_k)
                2'd0:    beat_byte = r_job.bits[23:16];
                2'd1:    beat_byte = r_job.bits[15:8];
                default: beat_byte = r_job.bits[7:0];
            endcase
            job_end = (r_k == 2'd2);
        end else begin
            beat_byte = pad ? 8'h3d : char_of(idx);
            job_end   = (r_k == 2'd3);
        end
    end

    assign out_free = !r_valid || i_ready;
    assign emit     = r_busy && out_free;
    // Next job loads straight behind the last beat, so jobs run without a gap.
    assign o_pop    = !i_q_empty && (!r_busy || (emit && job_end));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
        if (emit) begin
            r_byte <= beat_byte;
            r_last <= job_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_k     <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_k    <= 2'd0;
            end else if (emit) begin
                if (job_end) begin
                    r_busy <= 1'b0;
                    r_k    <= 2'd0;
                end else begin
                    r_k <= r_k + 2'd1;
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

### hw/rtl/base64_codec.sv
// Top level of the streaming base64 encoder/decoder.
//
// Input channel i_in: one beat per byte (encode) or character (decode),
// in_last marks the end of a string. Result channel o_out: one beat per
// output character or byte, out_last set on the final beat caused by an
// input beat. i_cfg_we/i_cfg_wdata write the mode bit (0 encode, 1 decode)
// and clear any partial group; write only while the block is idle.
// Encode: every third byte (or a last byte) yields four characters, with
// '=' padding for a short group. Decode: every fourth character yields
// three bytes; a short group at the end is dropped.
// A completing group is written into the job queue, loaded into the back
// end's job register, then registered into the output register. Throughput:
// the back end sends one beat per cycle while the receiver is ready, so encode
// sustains three input beats per four result beats and decode one per cycle;
// a last byte that closes a one-byte group still costs four result beats.
// That one-beat-per-cycle result port sets the figure. A job queue of QUEUE_DEPTH
// groups lets intake continue while results drain; input ready drops only when
// the queue is full, which a stalled receiver or a long encode run causes.
// After reset: encode mode, no partial group, queue and output empty.
module base64_codec #(
    parameter int QUEUE_DEPTH = b64_pkg::B64_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    b64_in_if.sink    i_in,
    b64_out_if.source o_out
);
    import b64_pkg::*;

    t_job q_in_job;
    t_job q_out_job;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    b64_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_byte      (i_in.in_byte),
        .i_last      (i_in.in_last),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (q_in_job)
    );

    b64_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (q_out_job)
    );

    b64_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_job   (q_out_job),
        .o_pop     (q_pop),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_byte    (o_out.out_byte),
        .o_last    (o_out.out_last)
    );

endmodule

### test/b64_codec_check.sv
// Channel monitor for the base64 codec: predicts every result beat and compares it.
module b64_codec_check (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    b64_in_if    i_in,
    b64_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import b64_pkg::*;

    localparam logic [7:0] PAD_IDX = 8'd64;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_coded;

    logic        mode_q;
    logic [23:0] grp_bits;
    logic [2:0]  grp_cnt;
    t_coded      transcoded_q[$];
    t_coded      got_beat;
    t_coded      want_beat;
    int          fails;

    function automatic logic [7:0] char_of(input logic [7:0] idx);
        if (idx < 8'd26) return "A" + idx;
        if (idx < 8'd52) return "a" + (idx - 8'd26);
        if (idx < 8'd62) return "0" + (idx - 8'd52);
        if (idx == 8'd62) return "+";
        if (idx == 8'd63) return "/";
        return "=";
    endfunction

    // Anything outside the alphabet, '=' included, is worth zero.
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return 6'(c - "A");
        if (c >= "a" && c <= "z") return 6'(c - "a" + 8'd26);
        if (c >= "0" && c <= "9") return 6'(c - "0" + 8'd52);
        if (c == "+") return 6'd62;
        if (c == "/") return 6'd63;
        return 6'd0;
    endfunction

    function automatic void owe(input logic [7:0] b, input logic last);
        t_coded beat;
        beat.out_byte = b;
        beat.out_last = last;
        transcoded_q.push_back(beat);
    endfunction

    function automatic void transcode(input logic [7:0] b, input logic last);
        logic [23:0] bits;
        logic [23:0] full;
        logic [2:0]  n;
        logic [7:0]  i2;
        logic [7:0]  i3;
        n = grp_cnt + 3'd1;
        if (mode_q == B64_MODE_ENCODE) begin
            bits = {grp_bits[15:0], b};
            if (n < 3'd3 && !last) begin
                grp_bits = bits;
                grp_cnt  = n;
                return;
            end
            // short group: left align and zero fill
            case (n)
                3'd1: full = {bits[7:0], 16'h0};
                3'd2: full = {bits[15:0], 8'h0};
                default: full = bits;
            endcase
            i2 = (n >= 3'd2) ? 8'(full[11:6]) : PAD_IDX;
            i3 = (n == 3'd3) ? 8'(full[5:0]) : PAD_IDX;
            owe(char_of(8'(full[23:18])), 1'b0);
            owe(char_of(8'(full[17:12])), 1'b0);
            owe(char_of(i2), 1'b0);
            owe(char_of(i3), 1'b1);
            grp_bits = '0;
            grp_cnt  = '0;
        end else begin
            bits = {grp_bits[17:0], sextet_of(b)};
            if (n == 3'd4) begin
                owe(bits[23:16], 1'b0);
                owe(bits[15:8], 1'b0);
                owe(bits[7:0], 1'b1);
                grp_bits = '0;
                grp_cnt  = '0;
            end else if (last) begin
                grp_bits = '0;
                grp_cnt  = '0;
            end else begin
                grp_bits = bits;
                grp_cnt  = n;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q   = B64_MODE_ENCODE;
            grp_bits = '0;
            grp_cnt  = '0;
            transcoded_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got_beat.out_byte = i_out.out_byte;
                got_beat.out_last = i_out.out_last;
                if (transcoded_q.size() == 0) begin
                    fails++;
                    $error("unexpected result beat: out_byte %h out_last %b",
                           got_beat.out_byte, got_beat.out_last);
                end else begin
                    want_beat = transcoded_q.pop_front();
                    if (got_beat.out_byte !== want_beat.out_byte) begin
                        fails++;
                        $error("out_byte: expected %h, got %h",
                               want_beat.out_byte, got_beat.out_byte);
                    end
                    if (got_beat.out_last !== want_beat.out_last) begin
                        fails++;
                        $error("out_last: expected %b, got %b",
                               want_beat.out_last, got_beat.out_last);
                    end
                end
            end
            // a mode write also drops any partial group
            if (i_cfg_we) begin
                mode_q   = i_cfg_wdata;
                grp_bits = '0;
                grp_cnt  = '0;
            end
            if (i_in.valid && i_in.ready) transcode(i_in.in_byte, i_in.in_last);
        end
        o_pending    <= transcoded_q.size();
        o_fail_count <= fails;
    end

endmodule

### test/tb_base64_codec.sv
// Top of the base64 codec testbench: clock, reset, stimulus, flow control and verdict.
module tb_base64_codec;
    timeunit 1ns;
    timeprecision 1ps;
    import b64_pkg::*;

    localparam int TOTAL_BEATS = 430;
    localparam int LONG_HOLD   = 80;
    localparam int SETTLE      = 8;
    localparam int STALL_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    b64_in_if  in_ch();
    b64_out_if out_ch();

    int   fail_count;
    int   pending_beats;
    int   beats_sent;
    int   idle_cycles;
    int   hold_asks;
    int   holds_served;
    int   stall_left;
    int   calm_left;
    int   tx_calm_left;
    logic burst_mode;

    base64_codec i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    b64_codec_check i_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Give up once nothing has moved on either channel for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side flow control: short and long stalls, calm stretches, and a
    // long hold-off whenever the stimulus asks for one.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != holds_served) begin
                holds_served++;
                stall_left = LONG_HOLD;
                calm_left  = 0;
            end else if (stall_left == 0 && calm_left == 0 && $urandom_range(0, 99) < 3) begin
                calm_left = $urandom_range(30, 120);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                out_ch.ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 40) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                         : $urandom_range(0, 2);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // One input beat; returns after the accepting edge and an optional gap.
    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        int r;
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        beats_sent++;
        if (burst_mode) begin
            gap = 0;
        end else if (tx_calm_left > 0) begin
            tx_calm_left--;
            gap = 0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                tx_calm_left = $urandom_range(20, 60);
                gap = 0;
            end else if (r < 55) begin
                gap = 0;
            end else if (r < 93) begin
                gap = $urandom_range(1, 3);
            end else begin
                gap = $urandom_range(8, 25);
            end
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1);
    endtask

    // Stop offering, let every owed beat arrive, then allow for work that
    // produces nothing (a dropped decode tail).
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] rand_b64_char();
        case ($urandom_range(0, 3))
            0: return 8'("A" + $urandom_range(0, 25));
            1: return 8'("a" + $urandom_range(0, 25));
            2: return 8'("0" + $urandom_range(0, 9));
            default: return $urandom_range(0, 1) ? "+" : "/";
        endcase
    endfunction

    initial begin
        int   phase;
        int   phase_end;
        int   len;
        int   pad;
        int   kind;
        logic cur_mode;
        logic paused;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        burst_mode    = 1'b0;
        paused        = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // encode from reset: full group, one- and two-byte padded tails, zero byte
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h7F, 1'b0);
        send_beat(8'h80, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h01, 1'b1);
        send_beat(8'h00, 1'b1);
        send_text("Man");

        set_mode(B64_MODE_DECODE);
        send_text("TWFu");
        send_text("+/9z");
        // characters outside the alphabet count as zero
        send_beat("=", 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat("{", 1'b1);
        // short group at the end is dropped
        send_text("QQ");

        phase = 0;
        while (beats_sent < TOTAL_BEATS) begin
            cur_mode = phase[0] ^ ($urandom_range(0, 4) == 0);
            set_mode(cur_mode);
            phase_end = beats_sent + $urandom_range(30, 70);
            if (phase == 2) begin
                // receiver holds off while beats keep coming, so the block backs up
                hold_asks <= hold_asks + 1;
                burst_mode = 1'b1;
            end
            while (beats_sent < phase_end) begin
                if (cur_mode == B64_MODE_ENCODE) begin
                    len = $urandom_range(1, 10);
                    for (int k = 0; k < len; k++) begin
                        if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'($urandom));
                        else send_beat(8'($urandom), k == len - 1);
                    end
                end else begin
                    kind = $urandom_range(0, 9);
                    if (kind < 7) begin
                        len = 4 * $urandom_range(1, 3);
                        pad = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
                        for (int k = 0; k < len; k++) begin
                            send_beat((k >= len - pad) ? "=" : rand_b64_char(), k == len - 1);
                        end
                    end else if (kind < 9) begin
                        len = $urandom_range(1, 7);
                        for (int k = 0; k < len; k++) send_beat(rand_b64_char(), k == len - 1);
                    end else begin
                        len = $urandom_range(1, 6);
                        for (int k = 0; k < len; k++) send_beat(8'($urandom), 1'($urandom));
                    end
                end
                if (phase == 4 && !paused) begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
            burst_mode = 1'b0;
            phase++;
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
